// ----- sv/fvswm_pkg.sv -----
`default_nettype none

package fvswm_pkg;

	localparam int STEP_BITS     = 32;
	localparam int LEVEL_BITS    = 16;
	localparam int LEVEL_SHIFT   = 15;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// pipeline control from the top level, shared by all voices
	typedef struct packed {
		logic tick;   // item with advance set accepted, phases step
		logic en_s1;  // first stage loads
		logic en_s2;  // second stage loads
	} fvswm_ctrl_t;

	// magnitude of one quarter-period entry: angle k << t_shift in q30 of a quarter turn,
	// odd taylor polynomial to degree 11 in q30, rounded to peak and clamped
	function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int t_shift,
		input logic [63:0] peak);
		logic [63:0] t;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] s;
		logic [63:0] y;
		logic [63:0] v;
		t  = k << t_shift;
		a  = (t * HALF_PI_Q30) >> 30;
		a2 = (a * a) >> 30;
		s  = Q30_ONE - (((a2 * Q30_ONE) >> 30) / 64'd110);
		s  = Q30_ONE - (((a2 * s) >> 30) / 64'd72);
		s  = Q30_ONE - (((a2 * s) >> 30) / 64'd42);
		s  = Q30_ONE - (((a2 * s) >> 30) / 64'd20);
		s  = Q30_ONE - (((a2 * s) >> 30) / 64'd6);
		y  = (a * s) >> 30;
		v  = (y * peak + (64'd1 << 29)) >> 30;
		if (v > peak) begin
			v = peak;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- sv/fvswm_sine_rom.sv -----
`default_nettype none

// full-period sine lookup built from a quarter-wave constant table
module fvswm_sine_rom import fvswm_pkg::*; #(
	parameter int TABLE_SIZE  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic [$clog2(TABLE_SIZE)-1:0] index,
	output logic signed [SAMPLE_BITS-1:0]      entry
);

	localparam int ADDR_BITS = $clog2(TABLE_SIZE);
	localparam int QBITS     = ADDR_BITS - 2;
	localparam int QUARTER   = TABLE_SIZE / 4;
	localparam int T_SHIFT   = 30 - QBITS;
	localparam int PEAK      = (1 << (SAMPLE_BITS - 1)) - 1;

	// quarter-turn point, reached only by the folded odd quadrants
	localparam logic [SAMPLE_BITS-2:0] TOP_MAG =
		(SAMPLE_BITS-1)'(quarter_sine(64'(QUARTER), T_SHIFT, 64'(PEAK)));

	logic [SAMPLE_BITS-2:0] quarter_tab [QUARTER];
	logic [1:0]             quad;
	logic [QBITS:0]         k;
	logic [SAMPLE_BITS-2:0] mag;

	for (genvar g = 0; g < QUARTER; g++) begin : g_tab
		assign quarter_tab[g] = (SAMPLE_BITS-1)'(quarter_sine(64'(g), T_SHIFT, 64'(PEAK)));
	end

	assign quad = index[ADDR_BITS-1 -: 2];

	// odd quadrants read the quarter wave backwards
	always_comb begin
		if (quad[0]) begin
			k = (QBITS+1)'(QUARTER) - {1'b0, index[QBITS-1:0]};
		end else begin
			k = {1'b0, index[QBITS-1:0]};
		end
	end

	assign mag = k[QBITS] ? TOP_MAG : quarter_tab[k[QBITS-1:0]];

	// second half of the period is negative
	always_comb begin
		if (quad[1]) begin
			entry = -$signed({1'b0, mag});
		end else begin
			entry = $signed({1'b0, mag});
		end
	end

endmodule

`default_nettype wire

// ----- sv/fvswm_voice.sv -----
`default_nettype none

// one voice: phase accumulator, table read, level scaling
module fvswm_voice import fvswm_pkg::*; #(
	parameter int TABLE_SIZE  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire fvswm_ctrl_t                ctrl,
	input  wire logic [STEP_BITS-1:0]       step,
	input  wire logic [LEVEL_BITS-1:0]      level,
	output logic signed [SAMPLE_BITS+1:0]   scaled
);

	localparam int ADDR_BITS = $clog2(TABLE_SIZE);
	localparam int PROD_BITS = SAMPLE_BITS + LEVEL_BITS + 1;

	logic [STEP_BITS-1:0]           phase_q;
	logic signed [SAMPLE_BITS-1:0]  entry;
	logic signed [SAMPLE_BITS-1:0]  entry_s1;
	logic signed [PROD_BITS-1:0]    prod;
	logic signed [SAMPLE_BITS+1:0]  scaled_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (ctrl.tick) begin
			phase_q <= phase_q + step;
		end
	end

	fvswm_sine_rom #(
		.TABLE_SIZE (TABLE_SIZE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_rom (
		.index(phase_q[STEP_BITS-1 -: ADDR_BITS]),
		.entry(entry)
	);

	// level is unsigned, so it gets a zero sign bit
	assign prod = PROD_BITS'(entry_s1) * PROD_BITS'($signed({1'b0, level}));

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			entry_s1 <= entry;
		end
		if (ctrl.en_s2) begin
			scaled_s2 <= prod[LEVEL_SHIFT +: SAMPLE_BITS+2];
		end
	end

	assign scaled = scaled_s2;

endmodule

`default_nettype wire

// ----- sv/four_voice_sine_wavetable_mixer.sv -----
// a sample item accepted passes entry_s1, scaled_s2 and mix_q before its mix shows on m_tvalid
// throughput: one item per cycle unless m_tready holds the output, set by the three-stage table/multiply/sum pipeline
// items with advance clear are accepted and give no result
// reset: asynchronous, active low; phases, steps, levels and valid flags clear to zero
// the sine table is constant logic and needs no fill after reset
`default_nettype none

module four_voice_sine_wavetable_mixer import fvswm_pkg::*; #(
	parameter int TABLE_SIZE  = 1024,   // power of two
	parameter int VOICE_COUNT = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	// sample tick items
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [7:0]                            s_tdata,   // [0] advance

	// mixed samples
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [((SAMPLE_BITS+2+7)/8)*8-1:0]         m_tdata,   // [SAMPLE_BITS+1:0] mix_sample

	// register writes: steps at 0..VOICE_COUNT-1, levels after them
	input  wire logic                                  wr_en,
	input  wire logic [$clog2(2*VOICE_COUNT)-1:0]      wr_index,
	input  wire logic [CFG_DATA_BITS-1:0]              wr_data
);

	localparam int OUT_BITS   = SAMPLE_BITS + 2;
	localparam int TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
	localparam int IDX_BITS   = $clog2(2 * VOICE_COUNT);

	logic [STEP_BITS-1:0]       step_q  [VOICE_COUNT];
	logic [LEVEL_BITS-1:0]      level_q [VOICE_COUNT];
	logic signed [OUT_BITS-1:0] scaled  [VOICE_COUNT];
	logic signed [OUT_BITS-1:0] mix_sum;
	logic [OUT_BITS-1:0]        mix_q;

	logic        v1_q;
	logic        v2_q;
	logic        out_valid_q;
	logic        en_out;
	fvswm_ctrl_t ctrl;

	// register file, writes outside the list fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				step_q[v]  <= '0;
				level_q[v] <= '0;
			end
		end else if (wr_en) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				if (wr_index == IDX_BITS'(v)) begin
					step_q[v] <= wr_data[STEP_BITS-1:0];
				end
				if (wr_index == IDX_BITS'(VOICE_COUNT + v)) begin
					level_q[v] <= wr_data[LEVEL_BITS-1:0];
				end
			end
		end
	end

	// each stage moves when the one after it is empty or moving
	assign en_out     = !out_valid_q || m_tready;
	assign ctrl.en_s2 = !v2_q || en_out;
	assign ctrl.en_s1 = !v1_q || ctrl.en_s2;
	assign s_tready   = ctrl.en_s1;
	assign ctrl.tick  = s_tvalid && s_tready && s_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.en_s1) begin
				v1_q <= ctrl.tick;
			end
			if (ctrl.en_s2) begin
				v2_q <= v1_q;
			end
			if (en_out) begin
				out_valid_q <= v2_q;
			end
		end
	end

	for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_voice
		fvswm_voice #(
			.TABLE_SIZE (TABLE_SIZE),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_voice (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.step  (step_q[g]),
			.level (level_q[g]),
			.scaled(scaled[g])
		);
	end

	// plain two's complement sum, wraps in the output width
	always_comb begin
		mix_sum = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			mix_sum = mix_sum + scaled[v];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			mix_q <= mix_sum;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_BITS'(mix_q);

endmodule

`default_nettype wire

// ----- tb/tb_mix_pkg.sv -----
`timescale 1ns / 1ps

package tb_mix_pkg;

	localparam int VOICES     = 4;
	localparam int ROM_DEPTH  = 1024;
	localparam int NUM_REGS   = 2 * VOICES;
	localparam int STEP_REG0  = 0;        // voice1_step .. voice4_step
	localparam int LEVEL_REG0 = VOICES;   // voice1_level .. voice4_level
	localparam int MIX_BITS   = 18;
	localparam int SHOW_LIMIT = 10;

	localparam longint unsigned Q30_UNIT        = 64'd1073741824;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam longint unsigned PEAK            = 64'd32767;

	// expected mix samples for the oscillator bank
	class mix_checker;
		logic signed [15:0]  sine_rom [ROM_DEPTH];
		logic [31:0]         step [VOICES];
		logic [15:0]         level [VOICES];
		logic [31:0]         phase [VOICES];
		logic [MIX_BITS-1:0] expected_mix [$];
		int                  checked;
		int                  fails;

		function new();
			for (int i = 0; i < ROM_DEPTH; i++) begin
				sine_rom[i] = sine_of(i);
			end
			for (int v = 0; v < VOICES; v++) begin
				step[v]  = '0;
				level[v] = '0;
				phase[v] = '0;
			end
			checked = 0;
			fails   = 0;
		endfunction

		// quadrant fold, odd taylor series to degree 11 in q30, round to peak
		function logic signed [15:0] sine_of(input int unsigned i);
			longint unsigned t, a, a2, s, y, v;
			logic [9:0] k;
			k = i[9:0];
			t = 64'(k[7:0]) << 22;
			if (k[8]) begin
				t = Q30_UNIT - t;
			end
			a  = (t * QUARTER_TURN_Q30) >> 30;
			a2 = (a * a) >> 30;
			s  = Q30_UNIT - (((a2 * Q30_UNIT) >> 30) / 64'd110);
			s  = Q30_UNIT - (((a2 * s) >> 30) / 64'd72);
			s  = Q30_UNIT - (((a2 * s) >> 30) / 64'd42);
			s  = Q30_UNIT - (((a2 * s) >> 30) / 64'd20);
			s  = Q30_UNIT - (((a2 * s) >> 30) / 64'd6);
			y  = (a * s) >> 30;
			v  = (y * PEAK + (64'd1 << 29)) >> 30;
			if (v > PEAK) begin
				v = PEAK;
			end
			return k[9] ? -v[15:0] : v[15:0];
		endfunction

		function void set_reg(input int idx, input logic [31:0] data);
			if (idx < LEVEL_REG0) begin
				step[idx - STEP_REG0] = data;
			end else if (idx < NUM_REGS) begin
				level[idx - LEVEL_REG0] = data[15:0];
			end
		endfunction

		// one accepted item: a tick reads every voice, then steps all phases
		function void note_tick(input logic advance);
			longint sum;
			if (!advance) begin
				return;
			end
			sum = 0;
			for (int v = 0; v < VOICES; v++) begin
				sum += (longint'(sine_rom[phase[v][31:22]]) * longint'(level[v])) >>> 15;
			end
			for (int v = 0; v < VOICES; v++) begin
				phase[v] = phase[v] + step[v];
			end
			expected_mix.push_back(sum[MIX_BITS-1:0]);
		endfunction

		function void check_mix(input logic [MIX_BITS-1:0] got);
			logic [MIX_BITS-1:0] want;
			checked++;
			if (expected_mix.size() == 0) begin
				fails++;
				if (fails <= SHOW_LIMIT) begin
					$display("mix %0d arrived with nothing pending", $signed(got));
				end
				return;
			end
			want = expected_mix.pop_front();
			if (got !== want) begin
				fails++;
				if (fails <= SHOW_LIMIT) begin
					$display("mix item %0d: expected %0d, got %0d", checked, $signed(want),
						$signed(got));
				end
			end
		endfunction

		function int pending();
			return expected_mix.size();
		endfunction
	endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import tb_mix_pkg::*;

	// clock, reset and all block inputs are known from time zero
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;     // [0] advance
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // [17:0] mix_sample
	logic        wr_en    = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [fvswm_pkg::CFG_DATA_BITS-1:0] wr_data = '0;

	// idling percentages for the two sides
	int src_idle_pct  = 20;
	int sink_idle_pct = 81;

	// run statistics
	int ticks_taken = 0;
	int idle_taken  = 0;
	int settings    = 0;

	// next register setting
	logic [31:0] next_step [VOICES];
	logic [15:0] next_level [VOICES];

	mix_checker mix_sb = new();

	four_voice_sine_wavetable_mixer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: back-pressure decided once per cycle at the falling edge
	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	// handshakes sampled at the rising edge; results are checked before the new item
	// is noted, which is harmless since a result is registered through entry_s1, scaled_s2 and mix_q after its tick
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				mix_sb.check_mix(m_tdata[MIX_BITS-1:0]);
			end
			if (s_tvalid && s_tready) begin
				mix_sb.note_tick(s_tdata[0]);
				if (s_tdata[0]) begin
					ticks_taken++;
				end else begin
					idle_taken++;
				end
			end
		end
	end

	// one item; entered and left at a falling edge, valid held high between
	// back-to-back items so it never toggles within one step
	task automatic send_tick(input logic advance);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, advance};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// wait for every pending mix, then cover the pipeline depth for no-tick items
	task automatic settle();
		while (mix_sb.pending() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// writes all eight registers back to back; level writes carry junk in the upper
	// half, which the block must drop
	task automatic apply_setting();
		logic [31:0] data;
		for (int r = STEP_REG0; r < NUM_REGS; r++) begin
			if (r < LEVEL_REG0) begin
				data = next_step[r - STEP_REG0];
			end else begin
				data = {16'($urandom), next_level[r - LEVEL_REG0]};
			end
			wr_en    <= 1'b1;
			wr_index <= 3'(r);
			wr_data  <= data;
			mix_sb.set_reg(r, data);
			@(negedge clk);
		end
		wr_en <= 1'b0;
		settings++;
	endtask

	// random setting weighted toward the extremes of steps and levels
	task automatic pick_setting();
		for (int v = 0; v < VOICES; v++) begin
			case ($urandom_range(5))
				0: next_step[v] = 32'h0;
				1: next_step[v] = 32'hFFFF_FFFF;
				2: next_step[v] = 32'h8000_0000;
				3: next_step[v] = 32'($urandom_range(1, 64)) << 22;
				4: next_step[v] = 32'($urandom_range(0, 32'h40_0000));
				default: next_step[v] = $urandom();
			endcase
			case ($urandom_range(4))
				0: next_level[v] = 16'd0;
				1: next_level[v] = 16'd32768;
				2: next_level[v] = 16'hFFFF;
				3: next_level[v] = 16'($urandom_range(0, 32768));
				default: next_level[v] = 16'($urandom());
			endcase
		end
	endtask

	// mostly ticks, with some no-tick items mixed in
	task automatic run_segment(input int ticks);
		int sent;
		sent = 0;
		while (sent < ticks) begin
			if ($urandom_range(99) < 85) begin
				send_tick(1'b1);
				sent++;
			end else begin
				send_tick(1'b0);
			end
		end
		s_tvalid <= 1'b0;
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: all levels zero, so a tick mixes to zero; a no-tick item
		// must give nothing
		send_tick(1'b1);
		send_tick(1'b0);
		s_tvalid <= 1'b0;
		settle();

		// phases are still zero: a sixteenth of a period per tick walks every voice
		// through both peaks together at level 0xffff, so the sum wraps both ways
		for (int v = 0; v < VOICES; v++) begin
			next_step[v]  = 32'h1000_0000;
			next_level[v] = 16'hFFFF;
		end
		apply_setting();
		for (int k = 0; k < 16; k++) begin
			send_tick(1'b1);
			if (k == 7) begin
				send_tick(1'b0);
			end
		end
		s_tvalid <= 1'b0;
		settle();

		// step extremes (max, none, one entry, half period) against full, zero,
		// just under full and minimal levels
		next_step[0]  = 32'hFFFF_FFFF;
		next_step[1]  = 32'h0;
		next_step[2]  = 32'h0040_0000;
		next_step[3]  = 32'h8000_0000;
		next_level[0] = 16'd32768;
		next_level[1] = 16'd0;
		next_level[2] = 16'd32767;
		next_level[3] = 16'd1;
		apply_setting();
		for (int k = 0; k < 6; k++) begin
			send_tick(1'b1);
		end
		s_tvalid <= 1'b0;
		settle();

		// random part in three idling phases, five settings each
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle_pct  = 20;
					sink_idle_pct = 81;
				end
				1: begin
					src_idle_pct  = 81;
					sink_idle_pct = 20;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int g = 0; g < 5; g++) begin
				pick_setting();
				apply_setting();
				run_segment(70);
			end
		end

		if (mix_sb.pending() != 0) begin
			$display("%0d expected mixes never arrived", mix_sb.pending());
			mix_sb.fails++;
		end
		$display("covered %0d sample ticks and %0d no-tick items over %0d register settings",
			ticks_taken, idle_taken, settings);
		$display("%0d mixes compared, with idling on either side, on both and on neither",
			mix_sb.checked);
		if (mix_sb.fails == 0) begin
			$display("[four_voice_sine_wavetable_mixer] OK");
		end else begin
			$display("[four_voice_sine_wavetable_mixer] ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[four_voice_sine_wavetable_mixer] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/fvswm_pkg.sv
sv/fvswm_sine_rom.sv
sv/fvswm_voice.sv
sv/four_voice_sine_wavetable_mixer.sv
tb/tb_mix_pkg.sv
tb/tb_top.sv
